// ===== src/tbdls_pkg.sv =====
// ----------------------------------------------------------------------------
// tbdls_pkg
// Shared types and constants of the text byte decoder and line splitter.
// ----------------------------------------------------------------------------
package tbdls_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = 2;
    localparam int LEVEL_W     = 3;
    localparam int ACC_W       = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [15:0] CH_CR = 16'h000D;
    localparam logic [15:0] CH_LF = 16'h000A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENCODING_MODE = 2'd0,
        CFG_LINE_MODE     = 2'd1
    } cfg_index_t;

    typedef enum logic {
        ENC_UTF8 = 1'b0,
        ENC_UCS2 = 1'b1
    } enc_mode_t;

    typedef enum logic [1:0] {
        LINE_CRLF = 2'd0,
        LINE_LF   = 2'd1,
        LINE_CR   = 2'd2,
        LINE_ANY  = 2'd3
    } line_mode_t;

    typedef enum logic [2:0] {
        KIND_CHAR       = 3'd0,
        KIND_LINE_END   = 3'd1,
        KIND_BAD_LEAD   = 3'd2,
        KIND_BAD_CONT   = 3'd3,
        KIND_ABOVE_FFFF = 3'd4,
        KIND_TRUNCATED  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        kind_t       kind;
        logic        last_of_run;
    } out_item_t;

    // Decoder to splitter: at most one unit or one error per byte.
    typedef struct packed {
        logic        unit_valid;
        logic [15:0] unit;
        logic        err_valid;
        kind_t       err_kind;
        logic        partial;
    } dec_out_t;

    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] items;
        logic [1:0]                  count;
    } result_set_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               can_take;
    } fifo_status_t;

    function automatic out_item_t make_result(input logic [15:0] unit, input kind_t kind);
        out_item_t r;
        r.code_unit   = unit;
        r.kind        = kind;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/text_byte_decoder_line_splitter_core.sv =====
// ----------------------------------------------------------------------------
// text_byte_decoder_line_splitter_core
// Byte stream to 16-bit code units (UTF-8 or UCS-2 LE), split into lines.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one raw byte per transfer (or a pure end marker); m_* carries
//   result items: characters, line ends and decode errors, with last_of_run on
//   the final result caused by an input transfer. cfg_* writes the encoding
//   mode (index 0) and line mode (index 1); write only while the block is idle.
//   A write to either register drops any partial character and pending CR.
// Decode and line split finish in the cycle the byte is taken; the results
//   are registered in the result queue and reach m_* behind any older ones.
// Throughput: one input transfer per cycle while each item yields at most one
//   result and m_ready stays high; an item with more results is drained one
//   at a time through the single read port of the four-entry result queue;
//   s_ready is high while the queue holds at most one result.
// Stall: when the receiver holds m_ready low the queue fills and s_ready
//   drops; nothing is lost. cfg_ready is always high.
// Reset: synchronous, active low; queue empty, encoding UCS-2 LE, line mode
//   CRLF, no decode or line state held.
// ----------------------------------------------------------------------------
module text_byte_decoder_line_splitter_core
    import tbdls_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    enc_mode_t    enc_mode_reg;
    line_mode_t   line_mode_reg;
    logic         accept;
    logic         cfg_write;
    logic         cfg_hit;
    dec_out_t     dec;
    result_set_t  results;
    fifo_status_t status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_write && ((cfg_index == CFG_ENCODING_MODE) ||
                                     (cfg_index == CFG_LINE_MODE));
    assign accept    = s_valid && s_ready;
    assign s_ready   = status.can_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_mode_reg  <= ENC_UCS2;
            line_mode_reg <= LINE_CRLF;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_ENCODING_MODE: enc_mode_reg  <= enc_mode_t'(cfg_data[0]);
                CFG_LINE_MODE:     line_mode_reg <= line_mode_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    tbdls_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (accept),
        .clear      (cfg_hit || (accept && s_data.stream_end)),
        .enc_mode   (enc_mode_reg),
        .data_byte  (s_data.data_byte),
        .byte_valid (s_data.byte_valid),
        .dec        (dec)
    );

    tbdls_split u_split (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cfg_clear  (cfg_hit),
        .line_mode  (line_mode_reg),
        .stream_end (s_data.stream_end),
        .dec        (dec),
        .results    (results)
    );

    tbdls_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (results),
        .pop        (m_valid && m_ready),
        .head       (m_data),
        .head_valid (m_valid),
        .status     (status)
    );

    a_code_zero_unless_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind != KIND_CHAR) |-> m_data.code_unit == 16'h0000)
        else $error("non-character result carries a code unit");

    a_level_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        status.level <= LEVEL_W'(FIFO_DEPTH))
        else $error("result queue level above depth");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        results.count != 2'd0 |->
            (status.level + LEVEL_W'(results.count)) <= LEVEL_W'(FIFO_DEPTH))
        else $error("result set does not fit the queue");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        results.count != 2'd0 |=> m_valid)
        else $error("results pushed but no result offered");

endmodule

// ===== src/tbdls_decode.sv =====
// ----------------------------------------------------------------------------
// tbdls_decode
// Byte decoder: UTF-8 (2 to 6 byte forms, up to 0xFFFF) or UCS-2 LE pairs.
// ----------------------------------------------------------------------------
module tbdls_decode
    import tbdls_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  logic      clear,
    input  enc_mode_t enc_mode,
    input  logic [7:0] data_byte,
    input  logic      byte_valid,
    output dec_out_t  dec
);

    logic [2:0]       remain_reg, remain_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] acc_shift;

    always_comb begin
        dec         = '0;
        remain_next = remain_reg;
        acc_next    = acc_reg;
        acc_shift   = {acc_reg[ACC_W-7:0], data_byte[5:0]};
        if (byte_valid) begin
            if (enc_mode == ENC_UCS2) begin
                if (remain_reg == 3'd0) begin
                    acc_next    = ACC_W'(data_byte);
                    remain_next = 3'd1;
                end else begin
                    dec.unit_valid = 1'b1;
                    dec.unit       = {data_byte, acc_reg[7:0]};
                    remain_next    = 3'd0;
                    acc_next       = '0;
                end
            end else if (remain_reg == 3'd0) begin
                if (!data_byte[7]) begin
                    dec.unit_valid = 1'b1;
                    dec.unit       = {8'h00, data_byte};
                end else begin
                    unique case (data_byte) inside
                        8'b110?????: begin
                            acc_next    = ACC_W'(data_byte[4:0]);
                            remain_next = 3'd1;
                        end
                        8'b1110????: begin
                            acc_next    = ACC_W'(data_byte[3:0]);
                            remain_next = 3'd2;
                        end
                        8'b11110???: begin
                            acc_next    = ACC_W'(data_byte[2:0]);
                            remain_next = 3'd3;
                        end
                        8'b111110??: begin
                            acc_next    = ACC_W'(data_byte[1:0]);
                            remain_next = 3'd4;
                        end
                        8'b1111110?: begin
                            acc_next    = ACC_W'(data_byte[0]);
                            remain_next = 3'd5;
                        end
                        default: begin
                            dec.err_valid = 1'b1;
                            dec.err_kind  = KIND_BAD_LEAD;
                        end
                    endcase
                end
            end else if (data_byte[7:6] != 2'b10) begin
                // drop the partial character together with the offending byte
                dec.err_valid = 1'b1;
                dec.err_kind  = KIND_BAD_CONT;
                remain_next   = 3'd0;
                acc_next      = '0;
            end else begin
                remain_next = remain_reg - 3'd1;
                if (remain_next == 3'd0) begin
                    acc_next = '0;
                    if (|acc_shift[ACC_W-1:16]) begin
                        dec.err_valid = 1'b1;
                        dec.err_kind  = KIND_ABOVE_FFFF;
                    end else begin
                        dec.unit_valid = 1'b1;
                        dec.unit       = acc_shift[15:0];
                    end
                end else begin
                    acc_next = acc_shift;
                end
            end
        end
        dec.partial = (remain_next != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            remain_reg <= 3'd0;
            acc_reg    <= '0;
        end else if (advance) begin
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

// ===== src/tbdls_split.sv =====
// ----------------------------------------------------------------------------
// tbdls_split
// Line splitter: turns one decoded unit, error and stream end into up to
// three results and tracks the pending CR and line content.
// ----------------------------------------------------------------------------
module tbdls_split
    import tbdls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        cfg_clear,
    input  line_mode_t  line_mode,
    input  logic        stream_end,
    input  dec_out_t    dec,
    output result_set_t results
);

    logic      cr_pending_reg, cr_pending_next;
    logic      has_content_reg, has_content_next;
    out_item_t res [0:3];
    logic [1:0] n;
    logic      done;
    logic      is_cr, is_lf;

    assign is_cr = (dec.unit == CH_CR);
    assign is_lf = (dec.unit == CH_LF);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            res[i] = make_result(16'h0000, KIND_CHAR);
        end
        n                = 2'd0;
        done             = 1'b0;
        cr_pending_next  = cr_pending_reg;
        has_content_next = has_content_reg;

        if (dec.err_valid) begin
            res[n] = make_result(16'h0000, dec.err_kind);
            n      = n + 2'd1;
        end else if (dec.unit_valid) begin
            unique case (line_mode)
                LINE_LF, LINE_CR: begin
                    if ((line_mode == LINE_LF && is_lf) || (line_mode == LINE_CR && is_cr)) begin
                        res[n]           = make_result(16'h0000, KIND_LINE_END);
                        n                = n + 2'd1;
                        has_content_next = 1'b0;
                    end else begin
                        res[n]           = make_result(dec.unit, KIND_CHAR);
                        n                = n + 2'd1;
                        has_content_next = 1'b1;
                    end
                end
                LINE_CRLF: begin
                    if (cr_pending_next) begin
                        cr_pending_next = 1'b0;
                        if (is_lf) begin
                            res[n]           = make_result(16'h0000, KIND_LINE_END);
                            n                = n + 2'd1;
                            has_content_next = 1'b0;
                            done             = 1'b1;
                        end else begin
                            res[n]           = make_result(CH_CR, KIND_CHAR);
                            n                = n + 2'd1;
                            has_content_next = 1'b1;
                        end
                    end
                    if (!done) begin
                        if (is_cr) begin
                            cr_pending_next = 1'b1;
                        end else begin
                            res[n]           = make_result(dec.unit, KIND_CHAR);
                            n                = n + 2'd1;
                            has_content_next = 1'b1;
                        end
                    end
                end
                LINE_ANY: begin
                    if (cr_pending_next) begin
                        cr_pending_next  = 1'b0;
                        res[n]           = make_result(16'h0000, KIND_LINE_END);
                        n                = n + 2'd1;
                        has_content_next = 1'b0;
                        done             = is_lf;
                    end
                    if (!done) begin
                        if (is_cr) begin
                            cr_pending_next = 1'b1;
                        end else if (is_lf) begin
                            res[n]           = make_result(16'h0000, KIND_LINE_END);
                            n                = n + 2'd1;
                            has_content_next = 1'b0;
                        end else begin
                            res[n]           = make_result(dec.unit, KIND_CHAR);
                            n                = n + 2'd1;
                            has_content_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (stream_end) begin
            if (dec.partial) begin
                res[n] = make_result(16'h0000, KIND_TRUNCATED);
                n      = n + 2'd1;
            end
            if (cr_pending_next || has_content_next) begin
                res[n] = make_result(16'h0000, KIND_LINE_END);
                n      = n + 2'd1;
            end
            cr_pending_next  = 1'b0;
            has_content_next = 1'b0;
        end

        if (n != 2'd0) begin
            res[n - 2'd1].last_of_run = 1'b1;
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            results.items[i] = res[i];
        end
        results.count = accept ? n : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cr_pending_reg  <= 1'b0;
            has_content_reg <= 1'b0;
        end else if (cfg_clear) begin
            cr_pending_reg  <= 1'b0;
        end else if (accept) begin
            cr_pending_reg  <= cr_pending_next;
            has_content_reg <= has_content_next;
        end
    end

endmodule

// ===== src/tbdls_fifo.sv =====
// ----------------------------------------------------------------------------
// tbdls_fifo
// Result queue: takes up to three results in one cycle, hands out one.
// ----------------------------------------------------------------------------
module tbdls_fifo
    import tbdls_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  result_set_t  push,
    input  logic         pop,
    output out_item_t    head,
    output logic         head_valid,
    output fifo_status_t status
);

    out_item_t          mem [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;

    assign level_next = level_reg + LEVEL_W'(push.count) - LEVEL_W'(pop);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < push.count) begin
                mem[wr_ptr_reg + PTR_W'(i)] <= push.items[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            level_reg  <= level_next;
        end
    end

    assign head            = mem[rd_ptr_reg];
    assign head_valid      = (level_reg != '0);
    assign status.level    = level_reg;
    // room for a full set of results from the next item
    assign status.can_take = (level_reg <= LEVEL_W'(FIFO_DEPTH - MAX_RESULTS));

endmodule

// ===== tb/text_decode_line_monitor.sv =====
// ----------------------------------------------------------------------------
// text_decode_line_monitor
// Watches the byte, result and register channels of the text byte decoder and
// line splitter, predicts every result from the accepted bytes and register
// writes, and compares each result transfer, field by field, against the
// oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module text_decode_line_monitor
    import tbdls_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    results_waiting,
    output int                    results_checked
);

    enc_mode_t  enc_sel;
    line_mode_t line_sel;
    logic [2:0]  owed_bytes;
    logic [31:0] code_bits;
    logic        cr_held;
    logic        line_open;

    out_item_t decoded_run [MAX_RESULTS];
    int        run_len;
    out_item_t decoded_units [$];

    task automatic add_result(input logic [15:0] unit, input kind_t kind);
        if (run_len < MAX_RESULTS) begin
            decoded_run[run_len].code_unit   = unit;
            decoded_run[run_len].kind        = kind;
            decoded_run[run_len].last_of_run = 1'b0;
            run_len++;
        end
    endtask

    task automatic emit_char(input logic [15:0] unit);
        add_result(unit, KIND_CHAR);
        line_open = 1'b1;
    endtask

    task automatic emit_line_end();
        add_result(16'h0000, KIND_LINE_END);
        line_open = 1'b0;
    endtask

    task automatic split_line(input logic [15:0] unit);
        logic swallow;
        case (line_sel)
            LINE_LF: begin
                if (unit == CH_LF) emit_line_end(); else emit_char(unit);
            end
            LINE_CR: begin
                if (unit == CH_CR) emit_line_end(); else emit_char(unit);
            end
            LINE_CRLF: begin
                if (cr_held && unit == CH_LF) begin
                    cr_held = 1'b0;
                    emit_line_end();
                end else begin
                    // a held CR not followed by LF is plain text
                    if (cr_held) begin
                        cr_held = 1'b0;
                        emit_char(CH_CR);
                    end
                    if (unit == CH_CR) cr_held = 1'b1; else emit_char(unit);
                end
            end
            default: begin
                swallow = cr_held && unit == CH_LF;
                if (cr_held) begin
                    cr_held = 1'b0;
                    emit_line_end();
                end
                if (!swallow) begin
                    if (unit == CH_CR) cr_held = 1'b1;
                    else if (unit == CH_LF) emit_line_end();
                    else emit_char(unit);
                end
            end
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int   lead_ones;
        logic counting;
        if (enc_sel == ENC_UCS2) begin
            if (owed_bytes == 3'd0) begin
                code_bits  = {24'h0, b};
                owed_bytes = 3'd1;
            end else begin
                owed_bytes = 3'd0;
                split_line({b, code_bits[7:0]});
                code_bits = '0;
            end
        end else if (owed_bytes == 3'd0) begin
            if (b <= 8'h7F) begin
                split_line({8'h00, b});
            end else begin
                lead_ones = 0;
                counting  = 1'b1;
                for (int i = 7; i >= 0; i--) begin
                    if (counting && b[i]) lead_ones++;
                    else counting = 1'b0;
                end
                if (lead_ones <= 1 || lead_ones > 6) begin
                    add_result(16'h0000, KIND_BAD_LEAD);
                end else begin
                    code_bits  = {24'h0, b & (8'hFF >> lead_ones)};
                    owed_bytes = 3'(lead_ones - 1);
                end
            end
        end else if (b[7:6] != 2'b10) begin
            // drop the partial character together with the offending byte
            owed_bytes = 3'd0;
            code_bits  = '0;
            add_result(16'h0000, KIND_BAD_CONT);
        end else begin
            code_bits  = (code_bits << 6) | {26'h0, b[5:0]};
            owed_bytes = owed_bytes - 3'd1;
            if (owed_bytes == 3'd0) begin
                if (code_bits > 32'h0000_FFFF) add_result(16'h0000, KIND_ABOVE_FFFF);
                else split_line(code_bits[15:0]);
                code_bits = '0;
            end
        end
    endtask

    task automatic predict_item(input in_item_t item);
        run_len = 0;
        if (item.byte_valid) decode_byte(item.data_byte);
        if (item.stream_end) begin
            if (owed_bytes != 3'd0) add_result(16'h0000, KIND_TRUNCATED);
            if (cr_held || line_open) emit_line_end();
            owed_bytes = '0;
            code_bits  = '0;
            cr_held    = 1'b0;
            line_open  = 1'b0;
        end
        if (run_len > 0) decoded_run[run_len-1].last_of_run = 1'b1;
        for (int k = 0; k < run_len; k++) decoded_units.push_back(decoded_run[k]);
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        if (idx == CFG_ENCODING_MODE || idx == CFG_LINE_MODE) begin
            if (idx == CFG_ENCODING_MODE) enc_sel = enc_mode_t'(value[0]);
            else line_sel = line_mode_t'(value[1:0]);
            owed_bytes = '0;
            code_bits  = '0;
            cr_held    = 1'b0;
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t got;
        out_item_t want;
        if (!aresetn) begin
            enc_sel    = ENC_UCS2;
            line_sel   = LINE_CRLF;
            owed_bytes = '0;
            code_bits  = '0;
            cr_held    = 1'b0;
            line_open  = 1'b0;
            decoded_units.delete();
        end else begin
            // retire before predicting: results of this transfer show up later
            if (m_valid && m_ready) begin
                got = m_data;
                if (decoded_units.size() == 0) begin
                    $display("%0t: result with none expected: unit=%h kind=%0d last=%b",
                             $time, got.code_unit, got.kind, got.last_of_run);
                    fail_count++;
                end else begin
                    want = decoded_units.pop_front();
                    if (got.code_unit !== want.code_unit || got.kind !== want.kind ||
                        got.last_of_run !== want.last_of_run) begin
                        $display("%0t: expected unit=%h kind=%0d last=%b, actual unit=%h kind=%0d last=%b",
                                 $time, want.code_unit, want.kind, want.last_of_run,
                                 got.code_unit, got.kind, got.last_of_run);
                        fail_count++;
                    end
                    results_checked++;
                end
            end
            if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
            if (s_valid && s_ready) predict_item(s_data);
        end
        results_waiting = decoded_units.size();
    end

endmodule

// ===== tb/text_byte_decoder_line_splitter_core_test.sv =====
// ----------------------------------------------------------------------------
// text_byte_decoder_line_splitter_core_test
// Drives byte streams through the decoder and line splitter under every
// encoding and line ending setting: directed corner cases first, then random
// well-formed text mixed with broken sequences, stream ends and noise, with
// bursty input and a stalling receiver. The monitor checks every result.
// ----------------------------------------------------------------------------
module text_byte_decoder_line_splitter_core_test;
    import tbdls_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int LATENCY_SETTLE = 4;
    localparam int RANDOM_ITEMS   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int results_waiting;
    int results_checked;
    int cycle_count = 0;
    int items_sent  = 0;
    int reg_writes  = 0;
    int burst_left  = 0;
    int ready_style = 0;
    int style_left  = 0;
    int stall_left  = 0;
    int beat_count  = 0;

    text_byte_decoder_line_splitter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    text_decode_line_monitor monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .results_checked (results_checked)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: switch between always ready, coin flips, one beat in four
    // and long stalls.
    always @(negedge aclk) begin
        if (style_left == 0) begin
            ready_style = $urandom_range(0, 3);
            style_left  = $urandom_range(16, 64);
        end else begin
            style_left--;
        end
        beat_count++;
        case (ready_style)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (beat_count % 4 == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    function automatic in_item_t byte_item(input logic [7:0] b, input logic fin);
        in_item_t item;
        item.data_byte  = b;
        item.byte_valid = 1'b1;
        item.stream_end = fin;
        return item;
    endfunction

    // byte_valid low: a pure end marker, or an empty item when fin is low
    function automatic in_item_t marker_item(input logic fin);
        in_item_t item;
        item.data_byte  = 8'($urandom);
        item.byte_valid = 1'b0;
        item.stream_end = fin;
        return item;
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return CH_CR[7:0];
        if (roll < 4) return CH_LF[7:0];
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic roll_stream_end();
        return $urandom_range(0, 15) == 0;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so a following call keeps the burst going.
    task automatic send_item(input in_item_t item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (results_waiting != 0) @(negedge aclk);
        // a byte that yields nothing may still be in flight
        repeat (LATENCY_SETTLE) @(negedge aclk);
    endtask

    task automatic apply_setting(input enc_mode_t enc, input line_mode_t line,
                                 input bit spare);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        int                    n;
        int                    first;
        first  = $urandom_range(0, 1);
        idx[0] = first ? CFG_LINE_MODE : CFG_ENCODING_MODE;
        idx[1] = first ? CFG_ENCODING_MODE : CFG_LINE_MODE;
        n = 2;
        if (spare) begin
            idx[2] = $urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3;
            n = 3;
        end
        for (int k = 0; k < n; k++) begin
            // upper data bits are don't-care; randomize them
            val[k] = 8'($urandom);
            if (idx[k] == CFG_ENCODING_MODE) val[k][0] = enc;
            else if (idx[k] == CFG_LINE_MODE) val[k][1:0] = line;
        end
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_text(input enc_mode_t enc, input int target);
        int         sent;
        int         pick;
        int         len;
        int         conts;
        logic [7:0] b;
        logic       fin;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (enc == ENC_UTF8 && pick < 35) begin
                send_item(byte_item(pick_text_byte(), roll_stream_end()));
                sent++;
            end else if (enc == ENC_UTF8 && pick < 90) begin
                len = (pick < 60) ? $urandom_range(2, 3) : $urandom_range(4, 6);
                b = ~(8'hFF >> len) | (8'($urandom) & (8'hFF >> (len + 1)));
                if (pick < 75) begin
                    // well-formed sequence
                    send_item(byte_item(b, len == 1'b0));
                    for (int k = 1; k < len; k++) begin
                        fin = (k == len - 1) && roll_stream_end();
                        send_item(byte_item(8'h80 | 8'($urandom_range(0, 63)), fin));
                    end
                    sent += len;
                end else begin
                    // cut short by a stray byte or by the end of the stream
                    conts = $urandom_range(0, len - 2);
                    send_item(byte_item(b, 1'b0));
                    for (int k = 0; k < conts; k++)
                        send_item(byte_item(8'h80 | 8'($urandom_range(0, 63)), 1'b0));
                    if (pick < 85) begin
                        b = 8'($urandom);
                        if (b[7:6] == 2'b10) b[6] = 1'b1;
                        send_item(byte_item(b, roll_stream_end()));
                    end else begin
                        send_item(marker_item(1'b1));
                    end
                    sent += conts + 2;
                end
            end else if (enc == ENC_UCS2 && pick < 85) begin
                b = (pick < 50) ? pick_text_byte() : 8'($urandom);
                send_item(byte_item(b, 1'b0));
                b = ($urandom_range(0, 9) < 7) ? 8'h00 : 8'($urandom);
                send_item(byte_item(b, roll_stream_end()));
                sent += 2;
            end else if (pick < 95) begin
                send_item(byte_item(8'($urandom), roll_stream_end()));
                sent++;
            end else if (pick < 98) begin
                send_item(marker_item(1'b1));
                sent++;
            end else begin
                send_item(marker_item(1'b0));
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset setting, UCS-2 LE with CRLF: a held CR followed by text gives
        // CR, the text and a line end; an odd byte at stream end is truncated.
        send_item(byte_item(CH_CR[7:0], 1'b0));
        send_item(byte_item(8'h00, 1'b0));
        send_item(byte_item(8'h41, 1'b0));
        send_item(byte_item(8'h00, 1'b1));
        send_item(byte_item(8'h7E, 1'b1));
        wait_idle();

        // UTF-8 with any line ending
        apply_setting(ENC_UTF8, LINE_ANY, 1'b1);
        send_item(byte_item(8'h41, 1'b0));
        send_item(byte_item(CH_CR[7:0], 1'b0));
        send_item(byte_item(CH_CR[7:0], 1'b0));
        send_item(byte_item(CH_LF[7:0], 1'b0));
        send_item(byte_item(CH_LF[7:0], 1'b0));
        send_item(byte_item(8'h80, 1'b0));
        send_item(byte_item(8'hFF, 1'b0));
        send_item(byte_item(8'hC3, 1'b0));
        send_item(byte_item(8'hA9, 1'b0));
        send_item(byte_item(8'hEF, 1'b0));
        send_item(byte_item(8'hBF, 1'b0));
        send_item(byte_item(8'hBF, 1'b0));
        send_item(byte_item(8'hF4, 1'b0));
        send_item(byte_item(8'h90, 1'b0));
        send_item(byte_item(8'h80, 1'b0));
        send_item(byte_item(8'h80, 1'b0));
        send_item(byte_item(8'hE2, 1'b0));
        send_item(byte_item(8'h41, 1'b0));
        send_item(byte_item(8'hE2, 1'b1));
        send_item(marker_item(1'b1));
        send_item(marker_item(1'b0));

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            apply_setting((p < 4) ? ENC_UTF8 : ENC_UCS2, line_mode_t'(p % 4), p % 3 == 0);
            send_random_text((p < 4) ? ENC_UTF8 : ENC_UCS2, RANDOM_ITEMS);
        end

        wait_idle();
        $display("%0d input items over all 8 encoding/line settings, %0d register writes",
                 items_sent, reg_writes);
        $display("%0d results checked, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0 && results_waiting == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
